/* sv/ptrc_pkg.sv */
// ----------------------------------------------------------------------------
// ptrc_pkg
// Shared types, constants and the microprogram of the tone and ring
// cadence generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrc_pkg;

    // number of lines served, 1 to 4
    localparam int LINES = 2;
    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    // field widths
    localparam int KIND_W = 2;
    localparam int LINE_W = 2;
    localparam int TONE_W = 2;
    localparam int PINS_W = 2;
    localparam int CNT_W  = 16;
    localparam int TGL_W  = 5;
    localparam int GATE_W = 6;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_TONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_RING = 2'd2;

    // tone codes
    localparam logic [TONE_W-1:0] TN_NONE  = 2'd0;
    localparam logic [TONE_W-1:0] TN_DIAL  = 2'd1;
    localparam logic [TONE_W-1:0] TN_RBACK = 2'd2;
    localparam logic [TONE_W-1:0] TN_BUSY  = 2'd3;

    // cadence limits in ticks
    localparam logic [CNT_W-1:0]  CAD_ON_END   = 16'd1000;
    localparam logic [CNT_W-1:0]  CAD_OFF_END  = 16'd3000;
    localparam logic [CNT_W-1:0]  CAD_BUSY_ON  = 16'd500;
    localparam logic [TGL_W-1:0]  TOGGLE_TICKS = 5'd25;
    localparam logic [GATE_W-1:0] GATE_RELOAD  = 6'd62;

    // microprogram addresses
    typedef logic [2:0] t_pc;
    localparam t_pc PC_IDLE = 3'd0;
    localparam t_pc PC_TONE = 3'd1;
    localparam t_pc PC_RING = 3'd2;
    localparam t_pc PC_EMIT = 3'd3;
    localparam t_pc PC_CMD  = 3'd4;

    // datapath operation of one step
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_TONE,
        OP_RING,
        OP_CMD,
        OP_EMIT
    } t_op;

    // sequencing condition of one step
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_MORE,
        COND_DISPATCH,
        COND_OUT_FREE
    } t_cond;

    // one control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  step_line;
    } t_ctrl;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic step_line;
        logic in_ready;
    } t_seq_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic              in_fire;
        logic [KIND_W-1:0] kind;
        logic              more;
        logic              out_free;
    } t_seq_status;

    // microprogram rom
    function automatic t_ctrl rom_word(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_WAIT, cond: COND_DISPATCH, target: PC_IDLE, step_line: 1'b0};
        unique case (pc)
            PC_IDLE: w = '{op: OP_WAIT, cond: COND_DISPATCH, target: PC_IDLE,
                           step_line: 1'b0};
            PC_TONE: w = '{op: OP_TONE, cond: COND_NEXT, target: PC_RING,
                           step_line: 1'b0};
            PC_RING: w = '{op: OP_RING, cond: COND_MORE, target: PC_TONE,
                           step_line: 1'b1};
            PC_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_FREE, target: PC_IDLE,
                           step_line: 1'b0};
            PC_CMD:  w = '{op: OP_CMD, cond: COND_JUMP, target: PC_EMIT,
                           step_line: 1'b0};
            default: w = '{op: OP_WAIT, cond: COND_JUMP, target: PC_IDLE,
                           step_line: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/ptrc_if.sv */
// ----------------------------------------------------------------------------
// ptrc_if
// Valid/ready channels for command transactions and pin level results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptrc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ptrc_pkg::KIND_W-1:0] kind;
    logic [ptrc_pkg::LINE_W-1:0] line;
    logic [ptrc_pkg::TONE_W-1:0] tone;
    logic                        ring_enable;

    modport source (output valid, kind, line, tone, ring_enable, input ready);
    modport sink   (input valid, kind, line, tone, ring_enable, output ready);
endinterface

interface ptrc_out_if;
    logic                        valid;
    logic                        ready;
    logic [ptrc_pkg::PINS_W-1:0] tone_pins;
    logic [ptrc_pkg::PINS_W-1:0] fr_pins;
    logic [ptrc_pkg::PINS_W-1:0] ring_mode_pins;

    modport source (output valid, tone_pins, fr_pins, ring_mode_pins, input ready);
    modport sink   (input valid, tone_pins, fr_pins, ring_mode_pins, output ready);
endinterface

`default_nettype wire

/* sv/ptrc_seq.sv */
// ----------------------------------------------------------------------------
// ptrc_seq
// Step counter and microprogram rom; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrc_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ptrc_pkg::t_seq_status i_status,
    output ptrc_pkg::t_seq_ctrl   o_ctrl
);

    ptrc_pkg::t_pc   r_pc;
    ptrc_pkg::t_pc   n_pc;
    ptrc_pkg::t_pc   pc_inc;
    ptrc_pkg::t_ctrl word;

    assign word   = ptrc_pkg::rom_word(r_pc);
    assign pc_inc = ptrc_pkg::t_pc'(r_pc + 3'd1);

    // next step selection
    always_comb begin
        n_pc = r_pc;
        unique case (word.cond)
            ptrc_pkg::COND_NEXT: n_pc = pc_inc;
            ptrc_pkg::COND_JUMP: n_pc = word.target;
            ptrc_pkg::COND_MORE: n_pc = i_status.more ? word.target : pc_inc;
            ptrc_pkg::COND_DISPATCH: begin
                if (i_status.in_fire) begin
                    priority case (i_status.kind)
                        ptrc_pkg::KIND_TICK:     n_pc = ptrc_pkg::PC_TONE;
                        ptrc_pkg::KIND_SET_TONE: n_pc = ptrc_pkg::PC_CMD;
                        ptrc_pkg::KIND_SET_RING: n_pc = ptrc_pkg::PC_CMD;
                        default:                 n_pc = ptrc_pkg::PC_EMIT;
                    endcase
                end
            end
            ptrc_pkg::COND_OUT_FREE: n_pc = i_status.out_free ? word.target : r_pc;
            default: n_pc = ptrc_pkg::PC_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ptrc_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // control outputs
    always_comb begin
        o_ctrl.op        = word.op;
        o_ctrl.step_line = word.step_line;
        o_ctrl.in_ready  = (word.cond == ptrc_pkg::COND_DISPATCH);
    end

endmodule

`default_nettype wire

/* sv/phone_tone_ring_cadence.sv */
// ----------------------------------------------------------------------------
// phone_tone_ring_cadence
// Per-line tone and ring cadence generator driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// flow: a tick is taken in the idle step, then each line takes a tone step
//   and a ring step through the one shared counter/compare datapath; a command
//   takes the command step, an unknown kind none; all then pass the emit step,
//   which waits while the output is held. No new transaction is taken before
//   the emit step has registered the result.
// reset: synchronous active low, all lines off, gate counter at 62
`default_nettype none

module phone_tone_ring_cadence (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ptrc_in_if.sink    i_in,
    ptrc_out_if.source o_out
);

    localparam int L = ptrc_pkg::LINES;

    ptrc_pkg::t_seq_ctrl   ctrl;
    ptrc_pkg::t_seq_status status;

    // per-line state
    logic [ptrc_pkg::TONE_W-1:0] r_tone_kind [L];
    logic                        r_ringing   [L];
    logic [ptrc_pkg::CNT_W-1:0]  r_cnt       [L];
    logic [ptrc_pkg::TGL_W-1:0]  r_tgl       [L];
    logic                        r_pol       [L];
    logic [L-1:0]                r_tone_pin;
    logic [L-1:0]                r_fr_pin;
    logic [L-1:0]                r_ring_pin;
    logic [ptrc_pkg::GATE_W-1:0] r_gate;

    // latched transaction
    logic [ptrc_pkg::IDX_W-1:0]  r_idx;
    logic [ptrc_pkg::KIND_W-1:0] r_kind;
    logic [ptrc_pkg::TONE_W-1:0] r_tone;
    logic                        r_en;
    logic                        r_cmd_ok;

    // result register
    logic                        r_out_valid;
    logic [ptrc_pkg::PINS_W-1:0] r_out_tone;
    logic [ptrc_pkg::PINS_W-1:0] r_out_fr;
    logic [ptrc_pkg::PINS_W-1:0] r_out_ring;

    // next values of the addressed line
    logic [ptrc_pkg::TONE_W-1:0] n_tone_kind;
    logic                        n_ringing;
    logic [ptrc_pkg::CNT_W-1:0]  n_cnt;
    logic [ptrc_pkg::TGL_W-1:0]  n_tgl;
    logic                        n_pol;
    logic                        n_tone_pin;
    logic                        n_fr_pin;
    logic                        n_ring_pin;
    logic [ptrc_pkg::GATE_W-1:0] n_gate;
    logic                        line_we;

    logic [ptrc_pkg::CNT_W-1:0]  cnt_inc;
    logic [ptrc_pkg::TGL_W-1:0]  tgl_inc;
    logic [ptrc_pkg::GATE_W-1:0] gate_dec;
    logic                        in_fire;
    logic                        out_free;
    logic                        more;
    logic [3:0]                  tone_all;
    logic [3:0]                  fr_all;
    logic [3:0]                  ring_all;

    ptrc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // handshake and sequencer status
    assign i_in.ready = ctrl.in_ready;
    assign in_fire    = ctrl.in_ready && i_in.valid;
    assign out_free   = !r_out_valid || o_out.ready;
    assign more       = ({1'b0, r_idx} != (ptrc_pkg::IDX_W + 1)'(L - 1));

    always_comb begin
        status.in_fire  = in_fire;
        status.kind     = i_in.kind;
        status.more     = more;
        status.out_free = out_free;
    end

    // shared counter/compare datapath
    assign cnt_inc  = ptrc_pkg::CNT_W'(r_cnt[r_idx] + 16'd1);
    assign tgl_inc  = ptrc_pkg::TGL_W'(r_tgl[r_idx] + 5'd1);
    assign gate_dec = ptrc_pkg::GATE_W'(r_gate - 6'd1);

    always_comb begin
        n_tone_kind = r_tone_kind[r_idx];
        n_ringing   = r_ringing[r_idx];
        n_cnt       = r_cnt[r_idx];
        n_tgl       = r_tgl[r_idx];
        n_pol       = r_pol[r_idx];
        n_tone_pin  = r_tone_pin[r_idx];
        n_fr_pin    = r_fr_pin[r_idx];
        n_ring_pin  = r_ring_pin[r_idx];
        n_gate      = r_gate;
        line_we     = 1'b0;
        unique case (ctrl.op)
            ptrc_pkg::OP_TONE: begin
                line_we = 1'b1;
                if (r_tone_kind[r_idx] != ptrc_pkg::TN_NONE) begin
                    n_cnt = cnt_inc;
                    priority if (r_tone_kind[r_idx] == ptrc_pkg::TN_DIAL) begin
                        n_tone_pin = 1'b1;
                    end else if (r_tone_kind[r_idx] == ptrc_pkg::TN_RBACK) begin
                        if (cnt_inc < ptrc_pkg::CAD_ON_END) begin
                            n_tone_pin = r_gate[ptrc_pkg::GATE_W-1];
                            n_gate     = (gate_dec == '0) ? ptrc_pkg::GATE_RELOAD
                                                          : gate_dec;
                        end else if (cnt_inc < ptrc_pkg::CAD_OFF_END) begin
                            n_tone_pin = 1'b0;
                        end else begin
                            n_cnt = '0;
                        end
                    end else begin
                        if (cnt_inc < ptrc_pkg::CAD_BUSY_ON) begin
                            n_tone_pin = 1'b1;
                        end else if (cnt_inc < ptrc_pkg::CAD_ON_END) begin
                            n_tone_pin = 1'b0;
                        end else begin
                            n_cnt = '0;
                        end
                    end
                end
            end
            ptrc_pkg::OP_RING: begin
                line_we = 1'b1;
                if (r_ringing[r_idx]) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc < ptrc_pkg::CAD_ON_END) begin
                        n_tgl = tgl_inc;
                        if (tgl_inc >= ptrc_pkg::TOGGLE_TICKS) begin
                            n_tgl    = '0;
                            n_pol    = !r_pol[r_idx];
                            n_fr_pin = !r_pol[r_idx];
                        end
                    end else if (cnt_inc < ptrc_pkg::CAD_OFF_END) begin
                        n_fr_pin = 1'b0;
                    end else begin
                        n_cnt = '0;
                    end
                end
            end
            ptrc_pkg::OP_CMD: begin
                line_we = r_cmd_ok;
                if (r_kind == ptrc_pkg::KIND_SET_TONE) begin
                    if (r_tone_kind[r_idx] != r_tone) begin
                        n_tone_kind = r_tone;
                        n_cnt       = '0;
                        if (r_tone == ptrc_pkg::TN_NONE) begin
                            n_tone_pin = 1'b0;
                        end
                    end
                end else if (r_kind == ptrc_pkg::KIND_SET_RING) begin
                    if (r_ringing[r_idx] != r_en) begin
                        n_ringing  = r_en;
                        n_cnt      = '0;
                        n_tgl      = '0;
                        n_pol      = 1'b0;
                        n_ring_pin = r_en;
                        if (!r_en) begin
                            n_fr_pin = 1'b0;
                        end
                    end
                end
            end
            default: line_we = 1'b0;
        endcase
    end

    // per-line state and shared gate counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) begin
                r_tone_kind[i] <= ptrc_pkg::TN_NONE;
                r_ringing[i]   <= 1'b0;
                r_cnt[i]       <= '0;
                r_tgl[i]       <= '0;
                r_pol[i]       <= 1'b0;
            end
            r_tone_pin <= '0;
            r_fr_pin   <= '0;
            r_ring_pin <= '0;
            r_gate     <= ptrc_pkg::GATE_RELOAD;
        end else begin
            if (line_we) begin
                r_tone_kind[r_idx] <= n_tone_kind;
                r_ringing[r_idx]   <= n_ringing;
                r_cnt[r_idx]       <= n_cnt;
                r_tgl[r_idx]       <= n_tgl;
                r_pol[r_idx]       <= n_pol;
                r_tone_pin[r_idx]  <= n_tone_pin;
                r_fr_pin[r_idx]    <= n_fr_pin;
                r_ring_pin[r_idx]  <= n_ring_pin;
            end
            r_gate <= n_gate;
        end
    end

    // transaction latch and line index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_kind   <= ptrc_pkg::KIND_TICK;
            r_cmd_ok <= 1'b0;
        end else if (in_fire) begin
            r_kind   <= i_in.kind;
            r_cmd_ok <= ({1'b0, i_in.line} < (ptrc_pkg::LINE_W + 1)'(L));
            if (i_in.kind == ptrc_pkg::KIND_TICK) begin
                r_idx <= '0;
            end else begin
                r_idx <= ptrc_pkg::IDX_W'(i_in.line);
            end
        end else if (ctrl.step_line && more) begin
            r_idx <= ptrc_pkg::IDX_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tone <= i_in.tone;
            r_en   <= i_in.ring_enable;
        end
    end

    // pin vectors widened to four lines, two reported
    assign tone_all = 4'(r_tone_pin);
    assign fr_all   = 4'(r_fr_pin);
    assign ring_all = 4'(r_ring_pin);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == ptrc_pkg::OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == ptrc_pkg::OP_EMIT && out_free) begin
            r_out_tone <= tone_all[ptrc_pkg::PINS_W-1:0];
            r_out_fr   <= fr_all[ptrc_pkg::PINS_W-1:0];
            r_out_ring <= ring_all[ptrc_pkg::PINS_W-1:0];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.tone_pins      = r_out_tone;
    assign o_out.fr_pins        = r_out_fr;
    assign o_out.ring_mode_pins = r_out_ring;

endmodule

`default_nettype wire
